>>> sv/assert_macros.svh
// Assertion macros for the checker file of the set store.
// No dependencies; included by siss_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property, sampled on the rising clock edge,
// held off while the synchronous active-low reset is asserted.
`define SISS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// Property checked at every rising edge, reset cycles included.
`define SISS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`endif

>>> sv/siss_pkg.sv
// Package for the sorted integer set store: sizes, opcodes, cell control.
// No dependencies; imported by every module of the block.
package siss_pkg;

    localparam int CAPACITY  = 256;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int OUT_CNT_W = 9;
    localparam int KEY_W     = 32;
    localparam int OP_W      = 2;
    localparam int GROUP     = 16;
    localparam int NGRP      = (CAPACITY + GROUP - 1) / GROUP;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    // Broadcast from the control to every cell
    typedef struct packed {
        logic             cap;    // latch compare flags
        logic             shift;  // perform the insert shift
        logic [KEY_W-1:0] key;    // biased key
    } t_cell_ctrl;

    // Flip the sign bit so unsigned order equals signed order
    function automatic logic [KEY_W-1:0] bias_key(input logic [KEY_W-1:0] raw);
        bias_key = raw ^ {1'b1, {(KEY_W-1){1'b0}}};
    endfunction

endpackage

>>> sv/siss_cell.sv
// One slot of the sorted chain: holds a value, compares it with the key.
// Depends on siss_pkg.
module siss_cell import siss_pkg::*; (
    input  logic             i_clk,
    input  t_cell_ctrl       i_ctrl,
    input  logic             i_occ,       // slot holds a member
    input  logic [KEY_W-1:0] i_prev_val,  // left neighbour's value
    input  logic             i_prev_gt,   // left neighbour is above key
    output logic [KEY_W-1:0] o_val,
    output logic             o_gt,
    output logic             o_eq
);

    logic [KEY_W-1:0] r_val;
    logic             r_gt;
    logic             r_eq;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cap) begin
            // empty slots count as above any key
            r_gt <= !i_occ || (r_val > i_ctrl.key);
            r_eq <= i_occ && (r_val == i_ctrl.key);
        end
        if (i_ctrl.shift && r_gt) begin
            r_val <= i_prev_gt ? i_prev_val : i_ctrl.key;
        end
    end

    assign o_val = r_val;
    assign o_gt  = r_gt;
    assign o_eq  = r_eq;

endmodule

>>> sv/sorted_integer_set_store.sv
// Sorted integer set store. Holds up to CAPACITY distinct signed 32-bit
// values in ascending order in a row of cells, one value per cell. Each
// input word carries an opcode in tuser (insert, look up, clear) and the
// value in tdata; each one yields exactly one result word giving found,
// inserted, full and the member count after the operation. An insert of a
// value already present reports found and changes nothing; an insert of a
// new value into a full set reports full and changes nothing. Opcode 3
// does nothing and reports the current count. Order of steps: the cells
// latch their compare flags on acceptance, the registered first level of
// an OR tree (groups of GROUP cells) gathers the match flags in the reduce
// step, and in the apply step the cells shift right by one place from the
// insertion point while the result word is registered. The input is ready
// again in the cycle after, so a new item is taken only once the last one
// has yielded its result; a stalled result holds the block in its last
// step. No clearing pass after reset: occupancy follows the member count.
// Depends on siss_pkg.
module sorted_integer_set_store import siss_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // [31:0] value
    input  logic [OP_W-1:0]       i_s_tuser,   // [1:0] opcode
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata    // [0] found, [1] inserted,
                                               // [2] full_res, [11:3] count
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RED   = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [KEY_W-1:0]      r_key;
    logic [OP_W-1:0]       r_op;
    logic [NGRP-1:0]       r_grp;
    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;

    logic                  w_s_acc;
    logic                  w_go;
    logic                  w_found;
    logic                  w_full;
    logic                  w_ins;
    logic                  w_clr;
    logic [KEY_W-1:0]      w_key;
    t_cell_ctrl            w_ctrl;

    logic [KEY_W-1:0]      w_val [CAPACITY];
    logic [CAPACITY-1:0]   w_gt;
    logic [CAPACITY-1:0]   w_eq;
    logic [NGRP*GROUP-1:0] w_eq_pad;

    // ---- handshake ------------------------------------------------------
    assign o_s_tready = (r_state == S_IDLE);
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    // last step may proceed once the output register is free
    assign w_go       = !r_m_valid || i_m_tready;

    // key straight from the port on acceptance, held copy afterwards
    assign w_key = (r_state == S_IDLE) ? bias_key(i_s_tdata) : r_key;

    assign w_ctrl.cap   = w_s_acc;
    assign w_ctrl.shift = (r_state == S_APPLY) && w_go && w_ins;
    assign w_ctrl.key   = w_key;

    // ---- cell row -------------------------------------------------------
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_W-1:0] w_pv;
        logic             w_pg;
        if (g == 0) begin : g_head
            assign w_pv = '0;
            assign w_pg = 1'b0;
        end else begin : g_body
            assign w_pv = w_val[g-1];
            assign w_pg = w_gt[g-1];
        end
        siss_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_occ      (CNT_W'(g) < r_count),
            .i_prev_val (w_pv),
            .i_prev_gt  (w_pg),
            .o_val      (w_val[g]),
            .o_gt       (w_gt[g]),
            .o_eq       (w_eq[g])
        );
    end

    // ---- match gather: first level of the OR tree is registered --------
    always_comb begin
        w_eq_pad = '0;
        w_eq_pad[CAPACITY-1:0] = w_eq;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RED) begin
            for (int k = 0; k < NGRP; k++) begin
                r_grp[k] <= |w_eq_pad[k*GROUP +: GROUP];
            end
        end
    end

    // ---- result decode --------------------------------------------------
    always_comb begin
        w_found = 1'b0;
        w_full  = 1'b0;
        w_ins   = 1'b0;
        w_clr   = 1'b0;
        unique case (r_op)
            OP_INSERT: begin
                w_found = |r_grp;
                w_full  = !w_found && (r_count >= CNT_W'(CAPACITY));
                w_ins   = !w_found && !w_full;
            end
            OP_LOOKUP: begin
                w_found = |r_grp;
            end
            OP_CLEAR: begin
                w_clr = 1'b1;
            end
            default: begin
                // unused opcode: no change
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_clr) begin
            n_count = '0;
        end else if (w_ins) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    // ---- sequencer ------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_s_acc) n_state = S_RED;
            S_RED:   n_state = S_APPLY;
            S_APPLY: if (w_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_APPLY && w_go) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // payload registers; result word zero-filled above the count
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_key <= bias_key(i_s_tdata);
            r_op  <= i_s_tuser;
        end
        if (r_state == S_APPLY && w_go) begin
            r_m_data <= OUT_DATA_W'({OUT_CNT_W'(n_count), w_full, w_ins, w_found});
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

>>> sv/siss_chk.sv
// Port-level checks for the sorted integer set store, bound to the top.
// Depends on siss_pkg and assert_macros.svh.
`include "assert_macros.svh"

module siss_chk import siss_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic [IN_DATA_W-1:0]  i_s_tdata,
    input logic [OP_W-1:0]       i_s_tuser,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata
);

    // a stalled result word holds
    `SISS_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))

    // one item at a time: no acceptance in the cycle after one
    `SISS_ASSERT(a_one_busy, i_clk, i_rst_n, i_s_tvalid && o_s_tready |=> !o_s_tready)

    // found, inserted and full are mutually exclusive
    `SISS_ASSERT(a_flags_excl, i_clk, i_rst_n, o_m_tvalid |-> $countones(o_m_tdata[2:0]) <= 1)

    // an insert always leaves a member behind
    `SISS_ASSERT(a_ins_count, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[1] |-> o_m_tdata[11:3] != 9'd0)

    // out of reset: no result pending, input side ready
    `SISS_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !o_m_tvalid && o_s_tready)

endmodule

bind sorted_integer_set_store siss_chk u_siss_chk (.*);
